// ----- rtl/core/mipe_pkg.sv -----
`timescale 1ns / 1ps

package mipe_pkg;

    // Default and upper bound of the buffered IP header depth, in 32-bit words.
    localparam int MAX_HDR_WORDS_DEF = 15;

    // Operation codes carried on the input tuser.
    localparam logic OP_ENCAP = 1'b0;
    localparam logic OP_DECAP = 1'b1;

    // Protocol written into the outer header after reset.
    localparam logic [7:0] ENCAP_PROTO_RST = 8'd55;

    // Size of the minimal forwarding header in bytes, and the smallest legal IHL.
    localparam logic [15:0] LEN_ADJ = 16'd8;
    localparam logic [3:0]  MIN_IHL = 4'd5;

    // Byte count of a full word.
    localparam logic [2:0] VB_FULL = 3'd4;

    // Checksum accumulator: up to fifteen words of two 16-bit halves each.
    localparam int CSUM_ACC_W = 21;

    // Fold the wide accumulator to 16 bits with end-around carry and invert.
    function automatic logic [15:0] csum_fold(input logic [CSUM_ACC_W-1:0] acc);
        logic [16:0] s1;
        logic [15:0] s2;
        s1 = {{(17 - (CSUM_ACC_W - 16)){1'b0}}, acc[CSUM_ACC_W-1:16]} + {1'b0, acc[15:0]};
        s2 = s1[15:0] + {15'b0, s1[16]};
        return ~s2;
    endfunction

endpackage

// ----- rtl/core/minimal_ip_encap_rewriter_unit.sv -----
`timescale 1ns / 1ps

// Minimal IP encapsulation rewriter. Packets enter as 32-bit beats in network byte order
// (first byte in bits 31..24); tuser selects encapsulation (0) or decapsulation (1) and is
// sampled on the first beat with the tunnel destination. The IP header (IHL words) and, when
// decapsulating, the 8-byte forwarding header are buffered; then one shared ones'-complement
// adder walks the buffered words under a small sequencer to build the checksums. Encapsulation
// builds the forwarding and then the IP header checksum and emits IHL+2 header beats;
// decapsulation builds only the latter and emits IHL beats. The input is stalled for that
// whole burst. Payload beats then pass at one per cycle, unless the output stalls, through a
// single output register. A packet that ends before its headers are complete is replayed
// from the buffer unchanged with tuser set, one beat per cycle unless the output stalls. A
// packet whose IHL is out of range passes unchanged. cfg_wr_en sets the encap protocol.
module minimal_ip_encap_rewriter_unit
    import mipe_pkg::*;
#(
    parameter int MAX_HEADER_WORDS = MAX_HDR_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,      // encap_protocol
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,     // packet_word[31:0], valid_bytes[34:32],
                                          // tunnel_dest[66:35], zero fill
    input  logic        s_axis_tlast,
    input  logic [0:0]  s_axis_tuser,     // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,     // out_word[31:0], out_valid_bytes[34:32], zero fill
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser      // truncated
);

    localparam int AW = $clog2(MAX_HEADER_WORDS);
    localparam int CW = $clog2(MAX_HEADER_WORDS + 3);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HDR   = 3'd1;
    localparam logic [2:0] PH_FWD   = 3'd2;
    localparam logic [2:0] PH_PAY   = 3'd3;
    localparam logic [2:0] PH_FSUM  = 3'd4;
    localparam logic [2:0] PH_HSUM  = 3'd5;
    localparam logic [2:0] PH_EMIT  = 3'd6;
    localparam logic [2:0] PH_FLUSH = 3'd7;

    localparam logic [CW-1:0] IDX_ZERO = CW'(0);
    localparam logic [CW-1:0] IDX_ONE  = CW'(1);
    localparam logic [CW-1:0] IDX_TWO  = CW'(2);
    localparam logic [CW-1:0] IDX_FOUR = CW'(4);

    // Header buffer and forwarding header words.
    logic [31:0] hdr_mem [MAX_HEADER_WORDS];
    logic [31:0] fwd_reg [2];

    // Control state.
    logic [2:0]            phase_reg, phase_next;
    logic [CW-1:0]         wcnt_reg, wcnt_next;
    logic [CW-1:0]         hw_reg, hw_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  mode_reg, mode_next;
    logic [31:0]           dest_reg, dest_next;
    logic [7:0]            proto_reg, proto_next;
    logic                  plast_reg, plast_next;
    logic [2:0]            fvb_reg, fvb_next;
    logic [CSUM_ACC_W-1:0] acc_reg, acc_next;
    logic [15:0]           fcsum_reg, fcsum_next;
    logic [15:0]           hcsum_reg, hcsum_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [31:0] o_word_reg;
    logic [2:0]  o_vb_reg;
    logic        o_last_reg;
    logic        o_tr_reg;

    logic        out_load;
    logic [31:0] out_word_d;
    logic [2:0]  out_vb_d;
    logic        out_last_d;
    logic        out_tr_d;

    // Input beat fields.
    logic [31:0] in_word;
    logic [2:0]  in_vb_raw;
    logic [2:0]  in_vb;
    logic [31:0] in_dest;
    logic        in_op;
    logic        in_short;
    logic [3:0]  in_ihl;
    logic        s_fire;
    logic        out_free;

    // Buffer write and read ports.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          fwd_we;
    logic          fwd_sel;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    // Rewritten header word, adder operand and the flush bookkeeping.
    logic [31:0]           mod_word;
    logic [31:0]           op_word;
    logic [CSUM_ACC_W-1:0] acc_sum;
    logic [CW-1:0]         wc_inc;
    logic [CW-1:0]         fwd_off;
    logic [CW-1:0]         fl_nh;
    logic [CW-1:0]         fl_nf_raw;
    logic [CW-1:0]         fl_nf;
    logic [CW-1:0]         fl_total;
    logic [CW-1:0]         fl_off;
    logic [CW-1:0]         emit_end;

    assign in_word   = s_axis_tdata[31:0];
    assign in_vb_raw = s_axis_tdata[34:32];
    assign in_dest   = s_axis_tdata[66:35];
    assign in_op     = s_axis_tuser[0];
    assign in_ihl    = in_word[27:24];
    assign in_vb     = (in_vb_raw == 3'd0 || in_vb_raw > VB_FULL) ? VB_FULL : in_vb_raw;
    assign in_short  = (in_vb != VB_FULL);

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (phase_reg == PH_IDLE || phase_reg == PH_HDR ||
                            phase_reg == PH_FWD || phase_reg == PH_PAY) && out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, o_vb_reg, o_word_reg};
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tuser  = o_tr_reg;

    // Flush counts: header words held, forwarding words held (at most two).
    assign fl_nh     = (wcnt_reg < hw_reg) ? wcnt_reg : hw_reg;
    assign fl_nf_raw = (wcnt_reg > hw_reg) ? (wcnt_reg - hw_reg) : IDX_ZERO;
    assign fl_nf     = (fl_nf_raw > IDX_TWO) ? IDX_TWO : fl_nf_raw;
    assign fl_total  = fl_nh + fl_nf;
    assign fl_off    = idx_reg - fl_nh;
    assign emit_end  = (mode_reg == OP_DECAP) ? (hw_reg - IDX_ONE) : (hw_reg + IDX_ONE);
    assign wc_inc    = wcnt_reg + IDX_ONE;
    assign fwd_off   = wcnt_reg - hw_reg;

    // Read address of the header buffer, chosen by the sequencer.
    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        unique case (phase_reg)
            PH_FSUM:
            begin
                rd_addr = (idx_reg == IDX_ZERO) ? AW'(2) : AW'(4);
            end
            PH_EMIT:
            begin
                if (idx_reg == hw_reg)
                begin
                    rd_addr = AW'(2);
                end
                else if (idx_reg > hw_reg)
                begin
                    rd_addr = AW'(4);
                end
            end
            default:
            begin
                rd_addr = idx_reg[AW-1:0];
            end
        endcase
    end

    assign rd_data = hdr_mem[rd_addr];

    // Outer header word with length, protocol, checksum and destination rewritten.
    always_comb
    begin
        mod_word = rd_data;
        if (idx_reg == IDX_ZERO)
        begin
            mod_word[15:0] = (mode_reg == OP_DECAP) ? (rd_data[15:0] - LEN_ADJ)
                                                    : (rd_data[15:0] + LEN_ADJ);
        end
        else if (idx_reg == IDX_TWO)
        begin
            mod_word[23:16] = (mode_reg == OP_DECAP) ? fwd_reg[0][31:24] : proto_reg;
            mod_word[15:0]  = (phase_reg == PH_EMIT) ? hcsum_reg : 16'h0000;
        end
        else if (idx_reg == IDX_FOUR)
        begin
            mod_word = (mode_reg == OP_DECAP) ? fwd_reg[1] : dest_reg;
        end
    end

    // Shared ones'-complement adder operand and sum.
    always_comb
    begin
        if (phase_reg == PH_FSUM)
        begin
            op_word = (idx_reg == IDX_ZERO) ? {rd_data[23:16], 24'h000000} : rd_data;
        end
        else
        begin
            op_word = mod_word;
        end
    end

    assign acc_sum = acc_reg + CSUM_ACC_W'(op_word[31:16]) + CSUM_ACC_W'(op_word[15:0]);

    // Sequencer.
    always_comb
    begin
        phase_next = phase_reg;
        wcnt_next  = wcnt_reg;
        hw_next    = hw_reg;
        idx_next   = idx_reg;
        mode_next  = mode_reg;
        dest_next  = dest_reg;
        proto_next = cfg_wr_en ? cfg_wr_data : proto_reg;
        plast_next = plast_reg;
        fvb_next   = fvb_reg;
        acc_next   = acc_reg;
        fcsum_next = fcsum_reg;
        hcsum_next = hcsum_reg;
        mem_we     = 1'b0;
        mem_waddr  = wcnt_reg[AW-1:0];
        fwd_we     = 1'b0;
        fwd_sel    = fwd_off[0];
        out_load   = 1'b0;
        out_word_d = in_word;
        out_vb_d   = in_vb;
        out_last_d = s_axis_tlast;
        out_tr_d   = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (s_fire)
                begin
                    mode_next = in_op;
                    dest_next = in_dest;
                    if (in_ihl < MIN_IHL || 32'(in_ihl) > MAX_HEADER_WORDS)
                    begin
                        out_load   = 1'b1;
                        phase_next = s_axis_tlast ? PH_IDLE : PH_PAY;
                    end
                    else
                    begin
                        hw_next   = CW'(in_ihl);
                        mem_we    = 1'b1;
                        mem_waddr = AW'(0);
                        wcnt_next = IDX_ONE;
                        fvb_next  = in_vb;
                        idx_next  = IDX_ZERO;
                        phase_next = s_axis_tlast ? PH_FLUSH : PH_HDR;
                    end
                end
            end
            PH_HDR:
            begin
                if (s_fire)
                begin
                    mem_we    = 1'b1;
                    wcnt_next = wc_inc;
                    fvb_next  = in_vb;
                    plast_next = s_axis_tlast;
                    idx_next  = IDX_ZERO;
                    acc_next  = '0;
                    if (wc_inc >= hw_reg)
                    begin
                        wcnt_next = hw_reg;
                        if (mode_reg == OP_ENCAP)
                        begin
                            phase_next = (s_axis_tlast && in_short) ? PH_FLUSH : PH_FSUM;
                        end
                        else
                        begin
                            phase_next = s_axis_tlast ? PH_FLUSH : PH_FWD;
                        end
                    end
                    else if (s_axis_tlast)
                    begin
                        phase_next = PH_FLUSH;
                    end
                end
            end
            PH_FWD:
            begin
                if (s_fire)
                begin
                    fwd_we     = 1'b1;
                    wcnt_next  = wc_inc;
                    fvb_next   = in_vb;
                    plast_next = s_axis_tlast;
                    idx_next   = IDX_ZERO;
                    acc_next   = '0;
                    if (wc_inc >= hw_reg + IDX_TWO)
                    begin
                        phase_next = (s_axis_tlast && in_short) ? PH_FLUSH : PH_HSUM;
                    end
                    else if (s_axis_tlast)
                    begin
                        phase_next = PH_FLUSH;
                    end
                end
            end
            PH_PAY:
            begin
                if (s_fire)
                begin
                    out_load = 1'b1;
                    if (s_axis_tlast)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_FSUM:
            begin
                // Two adder steps over the forwarding header, then fold.
                if (idx_reg == IDX_TWO)
                begin
                    fcsum_next = csum_fold(acc_reg);
                    acc_next   = '0;
                    idx_next   = IDX_ZERO;
                    phase_next = PH_HSUM;
                end
                else
                begin
                    acc_next = acc_sum;
                    idx_next = idx_reg + IDX_ONE;
                end
            end
            PH_HSUM:
            begin
                // One adder step per header word, then fold.
                if (idx_reg == hw_reg)
                begin
                    hcsum_next = csum_fold(acc_reg);
                    idx_next   = IDX_ZERO;
                    phase_next = PH_EMIT;
                end
                else
                begin
                    acc_next = acc_sum;
                    idx_next = idx_reg + IDX_ONE;
                end
            end
            PH_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_vb_d = VB_FULL;
                    if (idx_reg < hw_reg)
                    begin
                        out_word_d = mod_word;
                        out_last_d = (mode_reg == OP_DECAP) && plast_reg &&
                                     (idx_reg == emit_end);
                    end
                    else if (idx_reg == hw_reg)
                    begin
                        out_word_d = {rd_data[23:16], 8'h00, fcsum_reg};
                        out_last_d = 1'b0;
                    end
                    else
                    begin
                        out_word_d = rd_data;
                        out_last_d = plast_reg;
                    end
                    idx_next = idx_reg + IDX_ONE;
                    if (idx_reg == emit_end)
                    begin
                        wcnt_next  = IDX_ZERO;
                        phase_next = plast_reg ? PH_IDLE : PH_PAY;
                    end
                end
            end
            PH_FLUSH:
            begin
                // Replay the buffered words unchanged, marked truncated.
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_tr_d   = 1'b1;
                    out_word_d = (idx_reg < fl_nh) ? rd_data : fwd_reg[fl_off[0]];
                    out_last_d = (idx_reg == fl_total - IDX_ONE);
                    out_vb_d   = out_last_d ? fvb_reg : VB_FULL;
                    idx_next   = idx_reg + IDX_ONE;
                    if (out_last_d)
                    begin
                        wcnt_next  = IDX_ZERO;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            wcnt_reg    <= '0;
            hw_reg      <= '0;
            idx_reg     <= '0;
            mode_reg    <= 1'b0;
            dest_reg    <= '0;
            proto_reg   <= ENCAP_PROTO_RST;
            plast_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            wcnt_reg    <= wcnt_next;
            hw_reg      <= hw_next;
            idx_reg     <= idx_next;
            mode_reg    <= mode_next;
            dest_reg    <= dest_next;
            proto_reg   <= proto_next;
            plast_reg   <= plast_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers and the output beat.
    always_ff @(posedge clk)
    begin
        fvb_reg   <= fvb_next;
        acc_reg   <= acc_next;
        fcsum_reg <= fcsum_next;
        hcsum_reg <= hcsum_next;
        if (out_load)
        begin
            o_word_reg <= out_word_d;
            o_vb_reg   <= out_vb_d;
            o_last_reg <= out_last_d;
            o_tr_reg   <= out_tr_d;
        end
    end

    // Header buffer and forwarding header writes.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hdr_mem[mem_waddr] <= in_word;
        end
        if (fwd_we)
        begin
            fwd_reg[fwd_sel] <= in_word;
        end
    end

endmodule
